### rtl/pmp_pkg.sv
// Shared types and constants for the packet to M_PDU packer.
// No dependencies; every other file of the block imports this package.
package pmp_pkg;

  localparam int unsigned OFFS_W            = 11;
  localparam int unsigned FRAME_BYTES       = 1024;
  localparam int unsigned FILL_HEADER_BYTES = 6;

  localparam logic [OFFS_W-1:0] FRAME_LEN     = OFFS_W'(FRAME_BYTES);
  localparam logic [OFFS_W-1:0] FILL_MIN_LEN  = OFFS_W'(FILL_HEADER_BYTES + 1);
  localparam logic [OFFS_W-1:0] FILL_HDR_LEN  = OFFS_W'(FILL_HEADER_BYTES);
  localparam logic [10:0]       NO_HEADER     = 11'd2047;
  localparam logic [31:0]       FLUSH_DEFAULT = 32'd10000;

  // request and result kinds
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_TICK  = 1'b1;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [9:0]  frame_offset;
    logic [7:0]  out_byte;
    logic [10:0] run_length;
    logic [9:0]  run_fill_start;
    logic [10:0] fill_packet_length;
    logic        frame_done;
    logic [10:0] first_header_ptr;
    logic        last_of_run;
  } out_item_t;

  // up to two result words produced by one input word, packed from slot 0
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

endpackage

### rtl/pmp_core.sv
// Packer state and the single-pass logic that turns one input word into
// zero, one or two result words. Depends on pmp_pkg.
module pmp_core
  import pmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        item_accept,
  input  in_item_t    item,
  output res_pair_t   res
);

  logic [31:0]       flush_interval_r;
  logic [OFFS_W-1:0] write_offset_r, write_offset_nxt;
  logic              header_seen_r, header_seen_nxt;
  logic [OFFS_W-1:0] header_offset_r, header_offset_nxt;
  logic              packet_open_r, packet_open_nxt;
  logic [31:0]       idle_ticks_r, idle_ticks_nxt;
  logic [2:0]        spill_length_r, spill_length_nxt;
  logic [2:0]        spill_start_r, spill_start_nxt;

  always_comb begin
    logic [OFFS_W-1:0] wo;
    logic              hs;
    logic [OFFS_W-1:0] ho;
    logic [OFFS_W-1:0] wo_sum;
    logic [OFFS_W-1:0] remaining;
    logic [OFFS_W-1:0] flen;
    logic [OFFS_W-1:0] spill_len;
    logic              have_spill;
    logic              have_main;
    out_item_t         sp;
    out_item_t         rm;

    wo               = write_offset_r;
    hs               = header_seen_r;
    ho               = header_offset_r;
    packet_open_nxt  = packet_open_r;
    idle_ticks_nxt   = idle_ticks_r;
    spill_length_nxt = spill_length_r;
    spill_start_nxt  = spill_start_r;
    have_spill       = 1'b0;
    have_main        = 1'b0;
    sp               = '0;
    rm               = '0;
    wo_sum           = '0;
    remaining        = '0;
    flen             = '0;
    spill_len        = '0;

    // leftover tail of the last idle packet goes out first
    if (spill_length_r != 3'd0) begin
      have_spill            = 1'b1;
      sp.out_kind           = KIND_FILL;
      sp.frame_offset       = wo[9:0];
      sp.run_length         = {8'd0, spill_length_r};
      sp.run_fill_start     = {7'd0, spill_start_r};
      sp.fill_packet_length = FILL_MIN_LEN;
      wo_sum                = wo + {{(OFFS_W-3){1'b0}}, spill_length_r};
      idle_ticks_nxt        = '0;
      spill_length_nxt      = '0;
      spill_start_nxt       = '0;
      if (wo_sum >= FRAME_LEN) begin
        sp.frame_done       = 1'b1;
        sp.first_header_ptr = hs ? ho : NO_HEADER;
        wo                  = '0;
        hs                  = 1'b0;
        ho                  = '0;
      end else begin
        wo = wo_sum;
      end
    end

    if (item.req_type == REQ_BYTE) begin
      have_main       = 1'b1;
      rm.out_kind     = KIND_BYTE;
      rm.frame_offset = wo[9:0];
      rm.out_byte     = item.data_byte;
      if (!packet_open_nxt && !hs) begin
        hs = 1'b1;
        ho = wo;
      end
      packet_open_nxt = !item.last_of_packet;
      idle_ticks_nxt  = '0;
      wo_sum          = wo + OFFS_W'(1);
      if (wo_sum >= FRAME_LEN) begin
        rm.frame_done       = 1'b1;
        rm.first_header_ptr = hs ? ho : NO_HEADER;
        wo                  = '0;
        hs                  = 1'b0;
        ho                  = '0;
      end else begin
        wo = wo_sum;
      end
    end else begin
      if (idle_ticks_nxt != '1) begin
        idle_ticks_nxt = idle_ticks_nxt + 32'd1;
      end
      if (!packet_open_nxt && wo != '0 && idle_ticks_nxt >= flush_interval_r) begin
        // pad the rest of the frame; a fill always completes it
        have_main             = 1'b1;
        remaining             = FRAME_LEN - wo;
        flen                  = (remaining > FILL_HDR_LEN) ? remaining : FILL_MIN_LEN;
        rm.out_kind           = KIND_FILL;
        rm.frame_offset       = wo[9:0];
        rm.run_length         = remaining;
        rm.fill_packet_length = flen;
        rm.frame_done         = 1'b1;
        rm.first_header_ptr   = hs ? ho : wo;
        wo                    = '0;
        hs                    = 1'b0;
        ho                    = '0;
        idle_ticks_nxt        = '0;
        spill_len             = flen - remaining;
        spill_length_nxt      = spill_len[2:0];
        spill_start_nxt       = (spill_len[2:0] != 3'd0) ? remaining[2:0] : 3'd0;
      end
    end

    write_offset_nxt  = wo;
    header_seen_nxt   = hs;
    header_offset_nxt = ho;

    res = '0;
    if (have_spill && have_main) begin
      res.count          = 2'd2;
      res.r0             = sp;
      res.r1             = rm;
      res.r1.last_of_run = 1'b1;
    end else if (have_spill) begin
      res.count          = 2'd1;
      res.r0             = sp;
      res.r0.last_of_run = 1'b1;
    end else if (have_main) begin
      res.count          = 2'd1;
      res.r0             = rm;
      res.r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_interval_r <= FLUSH_DEFAULT;
      write_offset_r   <= '0;
      header_seen_r    <= 1'b0;
      header_offset_r  <= '0;
      packet_open_r    <= 1'b0;
      idle_ticks_r     <= '0;
      spill_length_r   <= '0;
      spill_start_r    <= '0;
    end else begin
      if (cfg_we) begin
        flush_interval_r <= cfg_data;
      end
      if (item_accept) begin
        write_offset_r  <= write_offset_nxt;
        header_seen_r   <= header_seen_nxt;
        header_offset_r <= header_offset_nxt;
        packet_open_r   <= packet_open_nxt;
        idle_ticks_r    <= idle_ticks_nxt;
        spill_length_r  <= spill_length_nxt;
        spill_start_r   <= spill_start_nxt;
      end
    end
  end

endmodule

### rtl/pmp_res_queue.sv
// Four-word result queue: takes up to two words per cycle, gives one per cycle while out_stall is low.
// Depends on pmp_pkg.
module pmp_res_queue
  import pmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  res_pair_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t  q_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] cnt_r;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push_en ? push.count : 2'd0;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for two words is needed before the next input word is taken
  assign full      = (cnt_r > 3'd2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

### rtl/packet_to_mpdu_packer_unit.sv
// Top level of the packet to M_PDU packer: packer core plus result queue.
// Depends on pmp_pkg, pmp_core and pmp_res_queue.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item_t (byte or tick)
//   out_     output     out_valid/out_stall out_item_t (byte or fill run)
//   cfg_     input      cfg_valid/cfg_ready flush interval, 32 bits
//
// One input word per cycle while in_stall is low. Its results are written to
// the queue at the accepting edge and show on out_ from the next cycle if it was empty.
// One word leaves per cycle while out_stall is low; a pending spill adds a word.
// in_stall rises when the four-word queue holds three or more words.
// Synchronous active-low reset clears the packer state, flush interval to
// its default of 10000 ticks, and empties the queue. cfg_ready is always high.
module packet_to_mpdu_packer_unit
  import pmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic      in_accept;
  logic      q_full;
  res_pair_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  pmp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .item_accept (in_accept),
    .item        (in_data),
    .res         (res)
  );

  pmp_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_accept),
    .push      (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
